// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion %m failed");

// Check a same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion %m failed");

// Check an implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion %m failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/pmad_pkg.sv
package pmad_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CNT_W       = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Shared multiplier: signed operands, one guard bit over 32.
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   // Speed compare: len * 10^6 on the left, (limit * dt)^2 on the right.
   localparam int TICK_W = 48;
   localparam int LHS_W  = 84;
   localparam int RHS_W  = 96;
   localparam int RATIO_W = 24;

   localparam logic [19:0] SPEED_SCALE   = 20'd1000000;
   localparam logic [6:0]  PERCENT_SCALE = 7'd100;

   // Register reset values.
   localparam logic [15:0] SPEED_LIMIT_RST    = 16'd6000;
   localparam logic [14:0] MIN_MOVE_RST       = 15'd20;
   localparam logic [15:0] EQ_LEN_LIMIT_RST   = 16'd10;
   localparam logic [15:0] EQ_SLOPE_LIMIT_RST = 16'd20;
   localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd300;
   localparam logic [6:0]  DIR_PERCENT_RST    = 7'd85;
   localparam logic [15:0] AXIS_TAN_RST       = 16'd13285;
   localparam logic [15:0] DIAG_TAN_RST       = 16'd43358;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_LIMIT,
      CSR_MIN_MOVE,
      CSR_EQ_LEN_LIMIT,
      CSR_EQ_SLOPE_LIMIT,
      CSR_WINDOW_LENGTH,
      CSR_DIR_PERCENT,
      CSR_AXIS_TAN,
      CSR_DIAG_TAN
   } csr_index_type;

   // Multiplier operations in issue order; the sequencer steps through them.
   typedef enum logic [3:0] {
      OP_AX2,
      OP_AY2,
      OP_AXIS,
      OP_DIAG,
      OP_LEN_LO,
      OP_LEN_HI,
      OP_SPD_DT,
      OP_ALIGN100,
      OP_PCTWIN,
      OP_T00,
      OP_T01,
      OP_T11,
      OP_SLOPE_A,
      OP_SLOPE_B
   } mul_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic       latch;
      logic       mul_en;
      mul_op_type op;
      logic       commit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

endpackage

// File: design/pmad_req_if.sv
interface pmad_req_if #(
   parameter int DELTA_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DELTA_BITS-1:0] delta_x;
   logic signed [DELTA_BITS-1:0] delta_y;
   logic [31:0]                  time_ms;

   modport source (output valid, delta_x, delta_y, time_ms, input ready);
   modport sink   (input valid, delta_x, delta_y, time_ms, output ready);
endinterface

// File: design/pmad_rsp_if.sv
interface pmad_rsp_if;
   logic valid;
   logic ready;
   logic checked;
   logic speed_alarm;
   logic spacing_alarm;
   logic slope_alarm;
   logic direction_alarm;

   modport source (output valid, checked, speed_alarm, spacing_alarm, slope_alarm,
                   direction_alarm, input ready);
   modport sink   (input valid, checked, speed_alarm, spacing_alarm, slope_alarm,
                   direction_alarm, output ready);
endinterface

// File: design/pmad_ctrl.sv
`include "assert_macros.svh"

module pmad_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pmad_pkg::dp_status_type status,
   output pmad_pkg::dp_cmd_type    cmd
);

   pmad_pkg::ctl_state_type state_ff, state_in;
   logic [3:0]              step_ff, step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         pmad_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pmad_pkg::ST_MUL;
               step_in  = '0;
            end
         end
         pmad_pkg::ST_MUL: begin
            if (step_ff == 4'(pmad_pkg::OP_SLOPE_B)) begin
               state_in = pmad_pkg::ST_DONE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         pmad_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = pmad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pmad_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready  = 1'b0;
      cmd.latch  = 1'b0;
      cmd.mul_en = 1'b0;
      cmd.op     = pmad_pkg::OP_AX2;
      cmd.commit = 1'b0;
      unique case (state_ff)
         pmad_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         pmad_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.op     = pmad_pkg::mul_op_type'(step_ff);
         end
         pmad_pkg::ST_DONE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pmad_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `ASSERT_NEXT(a_latch_starts_seq, clock, reset, cmd.latch, cmd.mul_en && cmd.op == pmad_pkg::OP_AX2)
   `ASSERT_ALWAYS(a_no_latch_commit, clock, reset, !(cmd.latch && cmd.commit))
   `ASSERT_IMPLIES(a_step_bound, clock, reset, cmd.mul_en, step_ff <= 4'(pmad_pkg::OP_SLOPE_B))

endmodule

// File: design/pmad_datapath.sv
`include "assert_macros.svh"

module pmad_datapath #(
   parameter int DELTA_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pmad_pkg::dp_cmd_type                      cmd,
   output pmad_pkg::dp_status_type                   status,
   input  logic                                      csr_we,
   input  logic [pmad_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [pmad_pkg::CSR_DATA_W-1:0]           csr_wdata,
   input  logic signed [DELTA_BITS-1:0]              in_dx,
   input  logic signed [DELTA_BITS-1:0]              in_dy,
   input  logic [31:0]                               in_time,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic                                      out_checked,
   output logic                                      out_speed_alarm,
   output logic                                      out_spacing_alarm,
   output logic                                      out_slope_alarm,
   output logic                                      out_direction_alarm
);

   localparam int DB    = DELTA_BITS;
   localparam int LEN_W = 2 * DELTA_BITS;
   localparam int MW    = pmad_pkg::MUL_W;
   localparam int PW    = pmad_pkg::PROD_W;
   localparam int CW    = pmad_pkg::CNT_W;

   // Configuration registers.
   logic [15:0] speed_limit_ff, eq_len_limit_ff, eq_slope_limit_ff, window_length_ff;
   logic [15:0] axis_tan_ff, diag_tan_ff;
   logic [14:0] min_move_ff;
   logic [6:0]  dir_percent_ff;

   // Current and previous report.
   logic signed [DB-1:0] cur_dx_ff, cur_dy_ff, prev_dx_ff, prev_dx_in, prev_dy_ff, prev_dy_in;
   logic [31:0]          cur_time_ff, prev_time_ff, prev_time_in;
   logic [LEN_W-1:0]     prev_len_ff, prev_len_in;
   logic                 have_prev_ff, have_prev_in;

   // Run and window counters.
   logic [CW-1:0] el_run_ff, el_run_in, sl_run_ff, sl_run_in;
   logic [CW-1:0] win_moves_ff, win_moves_in, aligned_ff, aligned_in;

   // Multiplier pipeline and partial results.
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    mul_p, prod_ff, slope_a_ff, slope_a_in;
   logic [PW-1:0]           prod_u;
   pmad_pkg::mul_op_type    prod_op_ff;
   logic                    prod_vld_ff;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [63:0]             len64;
   logic [pmad_pkg::LHS_W-1:0]   lhs_ff, lhs_in;
   logic [pmad_pkg::RHS_W-1:0]   rhs_ff, rhs_in;
   logic [pmad_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic [pmad_pkg::RATIO_W-1:0] a100_ff, a100_in, pctwin_ff, pctwin_in;
   logic                    axis_lt_ff, axis_lt_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic chk_ff, spd_ff, spc_ff, slp_ff, dir_ff;

   // Derived values.
   logic [DB-1:0]  ax, ay, lo, hi;
   logic [PW-1:0]  scaled;
   logic [31:0]    dt;
   logic           checked, aligned, len_eq, slope_eq, opp_x, opp_y, win_end;
   logic           spd, dir;
   logic           dx_pos, dx_neg, dy_pos, dy_neg, pdx_pos, pdx_neg, pdy_pos, pdy_neg;
   logic [CW-1:0]  el_next, sl_next;

   assign ax     = cur_dx_ff[DB-1] ? DB'($unsigned(-cur_dx_ff)) : DB'($unsigned(cur_dx_ff));
   assign ay     = cur_dy_ff[DB-1] ? DB'($unsigned(-cur_dy_ff)) : DB'($unsigned(cur_dy_ff));
   assign lo     = (ax < ay) ? ax : ay;
   assign hi     = (ax < ay) ? ay : ax;
   assign scaled = PW'({lo, 16'h0000});
   assign dt     = cur_time_ff - prev_time_ff;
   assign len64  = 64'(len_ff);
   assign prod_u = $unsigned(prod_ff);

   assign checked = have_prev_ff &&
                    (32'(ax) > 32'(min_move_ff) || 32'(ay) > 32'(min_move_ff));

   // Operand select for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         pmad_pkg::OP_AX2: begin
            mul_a = $signed(MW'(ax));
            mul_b = $signed(MW'(ax));
         end
         pmad_pkg::OP_AY2: begin
            mul_a = $signed(MW'(ay));
            mul_b = $signed(MW'(ay));
         end
         pmad_pkg::OP_AXIS: begin
            mul_a = $signed(MW'(axis_tan_ff));
            mul_b = $signed(MW'(hi));
         end
         pmad_pkg::OP_DIAG: begin
            mul_a = $signed(MW'(diag_tan_ff));
            mul_b = $signed(MW'(hi));
         end
         pmad_pkg::OP_LEN_LO: begin
            mul_a = $signed(MW'(len64[31:0]));
            mul_b = $signed(MW'(pmad_pkg::SPEED_SCALE));
         end
         pmad_pkg::OP_LEN_HI: begin
            mul_a = $signed(MW'(len64[63:32]));
            mul_b = $signed(MW'(pmad_pkg::SPEED_SCALE));
         end
         pmad_pkg::OP_SPD_DT: begin
            mul_a = $signed(MW'(speed_limit_ff));
            mul_b = $signed(MW'(dt));
         end
         pmad_pkg::OP_ALIGN100: begin
            mul_a = $signed(MW'(aligned_ff));
            mul_b = $signed(MW'(pmad_pkg::PERCENT_SCALE));
         end
         pmad_pkg::OP_PCTWIN: begin
            mul_a = $signed(MW'(dir_percent_ff));
            mul_b = $signed(MW'(win_moves_ff));
         end
         pmad_pkg::OP_T00: begin
            mul_a = $signed(MW'(tick_ff[31:0]));
            mul_b = $signed(MW'(tick_ff[31:0]));
         end
         pmad_pkg::OP_T01: begin
            mul_a = $signed(MW'(tick_ff[31:0]));
            mul_b = $signed(MW'(tick_ff[pmad_pkg::TICK_W-1:32]));
         end
         pmad_pkg::OP_T11: begin
            mul_a = $signed(MW'(tick_ff[pmad_pkg::TICK_W-1:32]));
            mul_b = $signed(MW'(tick_ff[pmad_pkg::TICK_W-1:32]));
         end
         pmad_pkg::OP_SLOPE_A: begin
            mul_a = MW'(cur_dy_ff);
            mul_b = MW'(prev_dx_ff);
         end
         pmad_pkg::OP_SLOPE_B: begin
            mul_a = MW'(prev_dy_ff);
            mul_b = MW'(cur_dx_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Sign classes for the quadrant test.
   assign dx_pos  = !cur_dx_ff[DB-1] && (cur_dx_ff != '0);
   assign dx_neg  = cur_dx_ff[DB-1];
   assign dy_pos  = !cur_dy_ff[DB-1] && (cur_dy_ff != '0);
   assign dy_neg  = cur_dy_ff[DB-1];
   assign pdx_pos = !prev_dx_ff[DB-1] && (prev_dx_ff != '0);
   assign pdx_neg = prev_dx_ff[DB-1];
   assign pdy_pos = !prev_dy_ff[DB-1] && (prev_dy_ff != '0);
   assign pdy_neg = prev_dy_ff[DB-1];
   assign opp_x   = (dx_pos && pdx_neg) || (dx_neg && pdx_pos);
   assign opp_y   = (dy_pos && pdy_neg) || (dy_neg && pdy_pos);

   // The last product (prev_dy * dx) stays in prod_ff until commit.
   assign slope_eq = (slope_a_ff == prod_ff) &&
                     ((cur_dx_ff == '0) == (prev_dx_ff == '0));
   assign len_eq   = (len_ff == prev_len_ff);
   assign el_next  = len_eq ? pmad_pkg::sat_inc(el_run_ff) : '0;
   assign sl_next  = (!opp_x && !opp_y && slope_eq) ? pmad_pkg::sat_inc(sl_run_ff) : '0;
   assign win_end  = (win_moves_ff >= window_length_ff);
   assign dir      = win_end && (a100_ff > pctwin_ff);
   assign spd      = (dt != 32'd0) && (pmad_pkg::RHS_W'(lhs_ff) > rhs_ff);
   assign aligned  = axis_lt_ff || (scaled > prod_u);

   always_comb begin
      len_in       = len_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      tick_in      = tick_ff;
      a100_in      = a100_ff;
      pctwin_in    = pctwin_ff;
      axis_lt_in   = axis_lt_ff;
      slope_a_in   = slope_a_ff;
      win_moves_in = win_moves_ff;
      aligned_in   = aligned_ff;
      el_run_in    = el_run_ff;
      sl_run_in    = sl_run_ff;
      have_prev_in = have_prev_ff;
      prev_dx_in   = prev_dx_ff;
      prev_dy_in   = prev_dy_ff;
      prev_time_in = prev_time_ff;
      prev_len_in  = prev_len_ff;

      // Fold in the product issued last cycle.
      if (prod_vld_ff) begin
         unique case (prod_op_ff)
            pmad_pkg::OP_AX2:      len_in = LEN_W'(prod_u);
            pmad_pkg::OP_AY2:      len_in = len_ff + LEN_W'(prod_u);
            pmad_pkg::OP_AXIS:     axis_lt_in = (scaled < prod_u);
            pmad_pkg::OP_DIAG: begin
               if (checked) begin
                  win_moves_in = pmad_pkg::sat_inc(win_moves_ff);
                  if (aligned) begin
                     aligned_in = pmad_pkg::sat_inc(aligned_ff);
                  end
               end
            end
            pmad_pkg::OP_LEN_LO:   lhs_in = pmad_pkg::LHS_W'(prod_u);
            pmad_pkg::OP_LEN_HI:   lhs_in = lhs_ff + (pmad_pkg::LHS_W'(prod_u) << 32);
            pmad_pkg::OP_SPD_DT:   tick_in = pmad_pkg::TICK_W'(prod_u);
            pmad_pkg::OP_ALIGN100: a100_in = pmad_pkg::RATIO_W'(prod_u);
            pmad_pkg::OP_PCTWIN:   pctwin_in = pmad_pkg::RATIO_W'(prod_u);
            pmad_pkg::OP_T00:      rhs_in = pmad_pkg::RHS_W'(prod_u);
            pmad_pkg::OP_T01:      rhs_in = rhs_ff + (pmad_pkg::RHS_W'(prod_u) << 33);
            pmad_pkg::OP_T11:      rhs_in = rhs_ff + (pmad_pkg::RHS_W'(prod_u) << 64);
            pmad_pkg::OP_SLOPE_A:  slope_a_in = prod_ff;
            default:               slope_a_in = slope_a_ff;
         endcase
      end

      // Retire the report: advance runs, close the window, shift to previous.
      if (cmd.commit) begin
         if (checked) begin
            el_run_in = el_next;
            sl_run_in = sl_next;
            if (win_end) begin
               win_moves_in = '0;
               aligned_in   = '0;
            end
         end
         have_prev_in = 1'b1;
         prev_dx_in   = cur_dx_ff;
         prev_dy_in   = cur_dy_ff;
         prev_time_in = cur_time_ff;
         prev_len_in  = len_ff;
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff    <= pmad_pkg::SPEED_LIMIT_RST;
         min_move_ff       <= pmad_pkg::MIN_MOVE_RST;
         eq_len_limit_ff   <= pmad_pkg::EQ_LEN_LIMIT_RST;
         eq_slope_limit_ff <= pmad_pkg::EQ_SLOPE_LIMIT_RST;
         window_length_ff  <= pmad_pkg::WINDOW_LENGTH_RST;
         dir_percent_ff    <= pmad_pkg::DIR_PERCENT_RST;
         axis_tan_ff       <= pmad_pkg::AXIS_TAN_RST;
         diag_tan_ff       <= pmad_pkg::DIAG_TAN_RST;
         have_prev_ff      <= 1'b0;
         prev_dx_ff        <= '0;
         prev_dy_ff        <= '0;
         prev_time_ff      <= '0;
         prev_len_ff       <= '0;
         el_run_ff         <= '0;
         sl_run_ff         <= '0;
         win_moves_ff      <= '0;
         aligned_ff        <= '0;
         prod_vld_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (pmad_pkg::csr_index_type'(csr_index))
               pmad_pkg::CSR_SPEED_LIMIT:    speed_limit_ff    <= csr_wdata;
               pmad_pkg::CSR_MIN_MOVE:       min_move_ff       <= csr_wdata[14:0];
               pmad_pkg::CSR_EQ_LEN_LIMIT:   eq_len_limit_ff   <= csr_wdata;
               pmad_pkg::CSR_EQ_SLOPE_LIMIT: eq_slope_limit_ff <= csr_wdata;
               pmad_pkg::CSR_WINDOW_LENGTH:  window_length_ff  <= csr_wdata;
               pmad_pkg::CSR_DIR_PERCENT:    dir_percent_ff    <= csr_wdata[6:0];
               pmad_pkg::CSR_AXIS_TAN:       axis_tan_ff       <= csr_wdata;
               pmad_pkg::CSR_DIAG_TAN:       diag_tan_ff       <= csr_wdata;
               default:                      diag_tan_ff       <= diag_tan_ff;
            endcase
         end
         have_prev_ff <= have_prev_in;
         prev_dx_ff   <= prev_dx_in;
         prev_dy_ff   <= prev_dy_in;
         prev_time_ff <= prev_time_in;
         prev_len_ff  <= prev_len_in;
         el_run_ff    <= el_run_in;
         sl_run_ff    <= sl_run_in;
         win_moves_ff <= win_moves_in;
         aligned_ff   <= aligned_in;
         prod_vld_ff  <= cmd.mul_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cur_dx_ff   <= in_dx;
         cur_dy_ff   <= in_dy;
         cur_time_ff <= in_time;
      end
      if (cmd.mul_en) begin
         prod_ff    <= mul_p;
         prod_op_ff <= cmd.op;
      end
      len_ff     <= len_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      tick_ff    <= tick_in;
      a100_ff    <= a100_in;
      pctwin_ff  <= pctwin_in;
      axis_lt_ff <= axis_lt_in;
      slope_a_ff <= slope_a_in;
      if (cmd.commit) begin
         chk_ff <= checked;
         spd_ff <= checked && spd;
         spc_ff <= checked && (el_next >= eq_len_limit_ff);
         slp_ff <= checked && (sl_next >= eq_slope_limit_ff);
         dir_ff <= checked && dir;
      end
   end

   assign out_valid           = rsp_valid_ff;
   assign out_checked         = chk_ff;
   assign out_speed_alarm     = spd_ff;
   assign out_spacing_alarm   = spc_ff;
   assign out_slope_alarm     = slp_ff;
   assign out_direction_alarm = dir_ff;

   `ASSERT_IMPLIES(a_commit_slot_free, clock, reset, cmd.commit, status.out_free)
   `ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid_ff)
   `ASSERT_ALWAYS(a_aligned_in_window, clock, reset, aligned_ff <= win_moves_ff)

endmodule

// File: design/pointer_motion_anomaly_detector_core.sv
// The shared 33x33 multiplier forms 14 products per report, one per cycle,
//   then the report is retired into the output register once that is free,
//   and the sequencer returns to idle to take the next request transfer; a
//   new request is not taken before the previous report has retired.
// A finished result waits in the output register while the next report runs.
// Reset (synchronous, active high) restores register defaults, clears the
//   previous report, the run and window counters, and empties the output.
`include "assert_macros.svh"

module pointer_motion_anomaly_detector_core #(
   parameter int DELTA_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   pmad_req_if.sink                           req_chan,
   pmad_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [pmad_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pmad_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   pmad_pkg::dp_cmd_type    cmd;
   pmad_pkg::dp_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;

   // Sequencer: takes a request transfer in idle, walks the multiplier
   // schedule, then retires the report once the output slot is free.
   pmad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, report history, the shared
   // multiplier with its partial-product accumulators, counters and the
   // output register.
   pmad_datapath #(
      .DELTA_BITS (DELTA_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .in_dx               (DELTA_BITS'(req_chan.delta_x)),
      .in_dy               (DELTA_BITS'(req_chan.delta_y)),
      .in_time             (req_chan.time_ms),
      .out_valid           (rsp_valid),
      .out_ready           (rsp_chan.ready),
      .out_checked         (rsp_chan.checked),
      .out_speed_alarm     (rsp_chan.speed_alarm),
      .out_spacing_alarm   (rsp_chan.spacing_alarm),
      .out_slope_alarm     (rsp_chan.slope_alarm),
      .out_direction_alarm (rsp_chan.direction_alarm)
   );

   // Hold ready only while the sequencer sits idle.
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

// File: tb/sv/pointer_motion_anomaly_detector_core_test.sv
module pointer_motion_anomaly_detector_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Quiet cycles after the last result, so that any stray result the core
   // still offers is caught.
   localparam int SETTLE_CYCLES    = 32;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int REPORT_LIMIT     = 10;
   localparam int PHASE_ITEMS      = 600;
   localparam int PEND_DEPTH       = 16;

   // One result item, first member in the MSB.
   typedef struct packed {
      logic checked;
      logic speed_alarm;
      logic spacing_alarm;
      logic slope_alarm;
      logic direction_alarm;
   } motion_flags_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   pmad_pkg::csr_index_type csr_index;
   logic [15:0]             csr_wdata;

   pmad_req_if #(.DELTA_BITS(16)) req_chan ();
   pmad_rsp_if                    rsp_chan ();

   pointer_motion_anomaly_detector_core #(.DELTA_BITS(16)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the register file.
   logic [15:0] lim_speed;
   logic [14:0] lim_move;
   logic [15:0] lim_len_run;
   logic [15:0] lim_slope_run;
   logic [15:0] lim_window;
   logic [6:0]  lim_percent;
   logic [15:0] tan_axis;
   logic [15:0] tan_diag;

   // Mirror of the detector state.
   bit                 seen_prior;
   logic signed [15:0] prior_dx;
   logic signed [15:0] prior_dy;
   logic [31:0]        prior_time;
   logic [15:0]        len_run;
   logic [15:0]        slope_run;
   logic [15:0]        win_moves;
   logic [15:0]        win_aligned;

   // Predictions in transfer order: stored by the sender, used by the checker.
   motion_flags_type pending_flags [PEND_DEPTH];
   int               pred_count = 0;
   int               pred_used  = 0;
   motion_flags_type observed_flags;
   motion_flags_type wanted_flags;
   string flag_names [5] = '{"direction_alarm", "slope_alarm", "spacing_alarm",
                             "speed_alarm", "checked"};

   int          mismatch_count = 0;
   int          results_seen   = 0;
   int          items_sent     = 0;
   int          send_idle_pct  = 0;
   int          recv_idle_pct  = 0;
   int          hold_request   = 0;
   int          hold_seen;
   int          hold_left;
   logic [31:0] clock_ms = 32'd0;

   // Clock: 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   function automatic logic [15:0] bump(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function automatic int sign_of(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic void apply_setting(input pmad_pkg::csr_index_type idx,
                                         input logic [15:0] value);
      case (idx)
         pmad_pkg::CSR_SPEED_LIMIT:    lim_speed     = value;
         pmad_pkg::CSR_MIN_MOVE:       lim_move      = value[14:0];
         pmad_pkg::CSR_EQ_LEN_LIMIT:   lim_len_run   = value;
         pmad_pkg::CSR_EQ_SLOPE_LIMIT: lim_slope_run = value;
         pmad_pkg::CSR_WINDOW_LENGTH:  lim_window    = value;
         pmad_pkg::CSR_DIR_PERCENT:    lim_percent   = value[6:0];
         pmad_pkg::CSR_AXIS_TAN:       tan_axis      = value;
         pmad_pkg::CSR_DIAG_TAN:       tan_diag      = value;
         default: ;
      endcase
   endfunction

   function automatic void clear_motion_model();
      lim_speed     = pmad_pkg::SPEED_LIMIT_RST;
      lim_move      = pmad_pkg::MIN_MOVE_RST;
      lim_len_run   = pmad_pkg::EQ_LEN_LIMIT_RST;
      lim_slope_run = pmad_pkg::EQ_SLOPE_LIMIT_RST;
      lim_window    = pmad_pkg::WINDOW_LENGTH_RST;
      lim_percent   = pmad_pkg::DIR_PERCENT_RST;
      tan_axis      = pmad_pkg::AXIS_TAN_RST;
      tan_diag      = pmad_pkg::DIAG_TAN_RST;
      seen_prior    = 1'b0;
      prior_dx      = '0;
      prior_dy      = '0;
      prior_time    = '0;
      len_run       = '0;
      slope_run     = '0;
      win_moves     = '0;
      win_aligned   = '0;
   endfunction

   // Work out the flags of one report and advance the mirrored state.
   function automatic motion_flags_type predict_report(input logic signed [15:0] dx,
                                                       input logic signed [15:0] dy,
                                                       input logic [31:0] now);
      motion_flags_type flags;
      longint        ax, ay, pax, pay, len_sq, prior_len_sq, lo, hi, scaled;
      logic [31:0]   elapsed;
      logic [127:0]  reach, moved, allowed;
      bit            same_quad, same_slope, aligned;
      flags = '0;
      ax = longint'(dx);
      ay = longint'(dy);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (seen_prior && (ax > longint'(lim_move) || ay > longint'(lim_move))) begin
         flags.checked = 1'b1;
         pax = longint'(prior_dx);
         pay = longint'(prior_dy);
         if (pax < 0) pax = -pax;
         if (pay < 0) pay = -pay;
         len_sq       = ax * ax + ay * ay;
         prior_len_sq = pax * pax + pay * pay;

         // Speed: skip the check when no time has passed.
         elapsed = now - prior_time;
         if (elapsed != 0) begin
            reach   = lim_speed * elapsed;
            moved   = len_sq * 128'd1000000;
            allowed = reach * reach;
            flags.speed_alarm = (moved > allowed);
         end

         len_run = (len_sq == prior_len_sq) ? bump(len_run) : 16'd0;
         flags.spacing_alarm = (len_run >= lim_len_run);

         // Vertical moves only match other vertical moves.
         same_quad  = (sign_of(longint'(dx)) * sign_of(longint'(prior_dx)) >= 0) &&
                      (sign_of(longint'(dy)) * sign_of(longint'(prior_dy)) >= 0);
         same_slope = (longint'(dy) * longint'(prior_dx) == longint'(prior_dy) * longint'(dx))
                      && ((dx == 0) == (prior_dx == 0));
         slope_run  = (same_quad && same_slope) ? bump(slope_run) : 16'd0;
         flags.slope_alarm = (slope_run >= lim_slope_run);

         // Compass alignment through Q0.16 tangent bounds.
         lo      = (ax < ay) ? ax : ay;
         hi      = (ax < ay) ? ay : ax;
         scaled  = lo << 16;
         aligned = (scaled < longint'(tan_axis) * hi) || (scaled > longint'(tan_diag) * hi);
         win_moves = bump(win_moves);
         if (aligned) win_aligned = bump(win_aligned);
         if (win_moves >= lim_window) begin
            flags.direction_alarm = (longint'(win_aligned) * 100 >
                                     longint'(lim_percent) * longint'(win_moves));
            win_moves   = '0;
            win_aligned = '0;
         end
      end
      seen_prior = 1'b1;
      prior_dx   = dx;
      prior_dy   = dy;
      prior_time = now;
      return flags;
   endfunction

   // ------------------------------------------------------------------
   // Result checking: compare every result transfer with the oldest
   // prediction, field by field.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         observed_flags = {rsp_chan.checked, rsp_chan.speed_alarm, rsp_chan.spacing_alarm,
                           rsp_chan.slope_alarm, rsp_chan.direction_alarm};
         if (pred_used == pred_count) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("result %0d arrived with nothing predicted: %b", results_seen,
                        observed_flags);
         end else begin
            wanted_flags = pending_flags[pred_used % PEND_DEPTH];
            pred_used++;
            for (int b = 4; b >= 0; b--) begin
               if (observed_flags[b] !== wanted_flags[b]) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("result %0d %s: expected %b, got %b", results_seen,
                              flag_names[b], wanted_flags[b], observed_flags[b]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side ready: random stalls, plus a long hold-off on request
   // so the core backs up into its input.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_seen      <= 0;
         hold_left      <= 0;
      end else begin
         if (hold_request != hold_seen) begin
            hold_seen      <= hold_request;
            hold_left      <= LONG_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left      <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (recv_idle_pct != 0) begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared stimulus tasks
   // ------------------------------------------------------------------

   // Offer one report and hold it until its transfer. Valid stays high
   // afterwards; the next call or a drain decides whether to drop it.
   task automatic send_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic [31:0] stamp);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.delta_x <= dx;
      req_chan.delta_y <= dy;
      req_chan.time_ms <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      pending_flags[pred_count % PEND_DEPTH] = predict_report(dx, dy, stamp);
      pred_count++;
      items_sent++;
   endtask

   // Advance the millisecond clock, then send.
   task automatic step_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic [31:0] step);
      clock_ms = clock_ms + step;
      send_report(dx, dy, clock_ms);
   endtask

   // Drop valid and wait until every predicted result has arrived.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pred_used != pred_count);
   endtask

   // Write all eight registers with the core idle.
   task automatic load_settings(input logic [15:0] speed, input logic [15:0] move,
                                input logic [15:0] len_limit, input logic [15:0] slope_limit,
                                input logic [15:0] window, input logic [15:0] percent,
                                input logic [15:0] axis, input logic [15:0] diag);
      logic [15:0] words [8];
      wait_for_results();
      words[pmad_pkg::CSR_SPEED_LIMIT]    = speed;
      words[pmad_pkg::CSR_MIN_MOVE]       = move;
      words[pmad_pkg::CSR_EQ_LEN_LIMIT]   = len_limit;
      words[pmad_pkg::CSR_EQ_SLOPE_LIMIT] = slope_limit;
      words[pmad_pkg::CSR_WINDOW_LENGTH]  = window;
      words[pmad_pkg::CSR_DIR_PERCENT]    = percent;
      words[pmad_pkg::CSR_AXIS_TAN]       = axis;
      words[pmad_pkg::CSR_DIAG_TAN]       = diag;
      for (int i = 0; i <= pmad_pkg::CSR_DIAG_TAN; i++) begin
         csr_we    <= 1'b1;
         csr_index <= pmad_pkg::csr_index_type'(i);
         csr_wdata <= words[i];
         @(posedge clock);
         apply_setting(pmad_pkg::csr_index_type'(i), words[i]);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // Mostly small moves, some medium, a fifth over the whole 16-bit range.
   function automatic logic signed [15:0] pick_delta();
      int pick;
      int v;
      pick = $urandom_range(99);
      if (pick >= 80) return 16'($urandom);
      v = (pick < 50) ? $urandom_range(0, 200) : $urandom_range(0, 4000);
      if ($urandom_range(1)) v = -v;
      return 16'(v);
   endfunction

   // Typical report spacing, repeated stamps, long pauses and wild jumps.
   function automatic logic [31:0] pick_step();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return $urandom_range(1, 20);
      if (pick < 80) return 32'd0;
      if (pick < 90) return $urandom_range(20, 2000);
      return $urandom;
   endfunction

   // Random gestures: runs that feed the run counters, equal-length turns,
   // compass-aligned strokes and plain noise.
   task automatic run_gestures(input int quota);
      int                 first, pick, reps, k, a, b, x, y, hi, lo;
      bit                 scalable;
      logic signed [15:0] bx, by;
      first = items_sent;
      while (items_sent - first < quota) begin
         pick = $urandom_range(99);
         reps = $urandom_range(3, 30);
         if (pick < 35) begin
            // Same direction, mostly the same vector, sometimes scaled up.
            bx = pick_delta();
            by = pick_delta();
            scalable = (bx > -10000 && bx < 10000 && by > -10000 && by < 10000);
            repeat (reps) begin
               k = (scalable && $urandom_range(2) == 0) ? $urandom_range(1, 3) : 1;
               step_report(16'(k * bx), 16'(k * by), pick_step());
            end
         end else if (pick < 55) begin
            // Equal length, turning between quadrants and axes.
            a = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 32767);
            b = $urandom_range(0, 300);
            repeat (reps) begin
               x = $urandom_range(1) ? a : b;
               y = (x == a) ? b : a;
               if ($urandom_range(1)) x = -x;
               if ($urandom_range(1)) y = -y;
               step_report(16'(x), 16'(y), pick_step());
            end
         end else if (pick < 75) begin
            // Strokes near an axis or near a diagonal, and in between.
            repeat (reps) begin
               hi = $urandom_range(1) ? $urandom_range(0, 300) : $urandom_range(0, 32767);
               case ($urandom_range(2))
                  0: lo = int'((longint'(hi) * $urandom_range(0, 14000)) >>> 16);
                  1: lo = int'((longint'(hi) * $urandom_range(42000, 65536)) >>> 16);
                  default: lo = $urandom_range(0, hi);
               endcase
               x = $urandom_range(1) ? hi : lo;
               y = (x == hi && hi != lo) ? lo : hi;
               if ($urandom_range(1)) x = -x;
               if ($urandom_range(1)) y = -y;
               step_report(16'(x), 16'(y), pick_step());
            end
         end else begin
            // Noise, including jitter below the move threshold.
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(3) == 0)
                  step_report(16'($urandom_range(0, 60) - 30), 16'($urandom_range(0, 60) - 30),
                              pick_step());
               else
                  step_report(pick_delta(), pick_delta(), pick_step());
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: first report, threshold edge, extreme deltas,
   // zero elapsed time and a timestamp wrap.
   task automatic test_threshold_and_extremes();
      send_report(16'sd0, 16'sd0, 32'd0);
      send_report(16'sd20, -16'sd20, 32'd5);
      send_report(-16'sd21, 16'sd0, 32'd9);
      send_report(16'sh8000, 16'sh7FFF, 32'd10);
      send_report(16'sh7FFF, 16'sh8000, 32'd10);
      send_report(16'sd100, 16'sd0, 32'hFFFF_FFF0);
      send_report(16'sd0, -16'sd100, 32'h0000_0010);
      clock_ms = 32'h0000_0010;
   endtask

   // All registers at zero: every checked report alarms, each one ends a window.
   task automatic test_zero_limits();
      load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      step_report(16'sd1, 16'sd0, 32'd3);
      step_report(16'sd0, 16'sd1, 32'd3);
      step_report(-16'sd1, -16'sd1, 32'd1);
      step_report(16'sd0, 16'sd0, 32'd1);
      step_report(16'sd1, 16'sd1, 32'd0);
   endtask

   // Short limits: speed at its exact bound, length and slope runs,
   // opposite quadrant, vertical runs and a small direction window.
   task automatic test_runs_and_window();
      load_settings(16'd10000, 16'd5, 16'd3, 16'd4, 16'd5, 16'd40,
                    pmad_pkg::AXIS_TAN_RST, pmad_pkg::DIAG_TAN_RST);
      step_report(16'sd6, 16'sd8, 32'd1);
      step_report(16'sd8, 16'sd6, 32'd1);
      step_report(16'sd30, 16'sd40, 32'd7);
      step_report(16'sd60, 16'sd80, 32'd7);
      step_report(16'sd30, 16'sd40, 32'd7);
      step_report(-16'sd30, -16'sd40, 32'd7);
      step_report(16'sd0, 16'sd50, 32'd7);
      step_report(16'sd0, 16'sd70, 32'd7);
      step_report(16'sd0, -16'sd90, 32'd7);
      step_report(16'sd1, 16'sd50, 32'd7);
   endtask

   // Every register at its top value, but the percentage at 100.
   task automatic test_extreme_settings();
      load_settings(16'd65535, 16'd32767, 16'd65535, 16'd65535, 16'd65535, 16'd100,
                    16'd65535, 16'd65535);
      step_report(16'sh8000, 16'sd0, 32'd1);
      step_report(16'sh8000, 16'sh8000, 32'd1);
      step_report(16'sh7FFF, 16'sh7FFF, 32'd1);
   endtask

   // Sender gaps light, receiver stalls heavy; tight limits so alarms fire.
   task automatic test_sender_idling();
      load_settings(pmad_pkg::SPEED_LIMIT_RST, 16'(pmad_pkg::MIN_MOVE_RST), 16'd6, 16'd8,
                    16'd20, 16'd60, pmad_pkg::AXIS_TAN_RST, pmad_pkg::DIAG_TAN_RST);
      set_idling(38, 52);
      run_gestures(PHASE_ITEMS);
   endtask

   // Sender gaps heavy, receiver stalls light, random settings.
   task automatic test_receiver_idling();
      load_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 60)),
                    16'($urandom_range(1, 12)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 40)), 16'($urandom_range(0, 100)),
                    16'($urandom_range(8000, 20000)), 16'($urandom_range(38000, 50000)));
      set_idling(52, 38);
      run_gestures(PHASE_ITEMS);
   endtask

   // Reset values back in place, full rate on both sides.
   task automatic test_full_rate();
      load_settings(pmad_pkg::SPEED_LIMIT_RST, 16'(pmad_pkg::MIN_MOVE_RST),
                    pmad_pkg::EQ_LEN_LIMIT_RST, pmad_pkg::EQ_SLOPE_LIMIT_RST,
                    pmad_pkg::WINDOW_LENGTH_RST, 16'(pmad_pkg::DIR_PERCENT_RST),
                    pmad_pkg::AXIS_TAN_RST, pmad_pkg::DIAG_TAN_RST);
      set_idling(0, 0);
      run_gestures(PHASE_ITEMS);
   endtask

   // Hold the result side off while reports keep coming, so the core
   // fills and stalls its request side.
   task automatic test_output_backpressure();
      wait_for_results();
      set_idling(0, 0);
      hold_request <= hold_request + 1;
      run_gestures(40);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= pmad_pkg::CSR_SPEED_LIMIT;
      csr_wdata        <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.delta_x <= '0;
      req_chan.delta_y <= '0;
      req_chan.time_ms <= '0;
      clear_motion_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_threshold_and_extremes();
      test_zero_limits();
      test_runs_and_window();
      test_extreme_settings();
      test_sender_idling();
      test_output_backpressure();
      test_receiver_idling();
      test_full_rate();

      // Drain, then watch a while for anything unpredicted.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pred_used == pred_count)
         $display("PASS pointer_motion_anomaly_detector_core");
      else
         $display("FAIL pointer_motion_anomaly_detector_core");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("FAIL pointer_motion_anomaly_detector_core");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/pmad_pkg.sv
design/pmad_req_if.sv
design/pmad_rsp_if.sv
design/pmad_ctrl.sv
design/pmad_datapath.sv
design/pointer_motion_anomaly_detector_core.sv
tb/sv/pointer_motion_anomaly_detector_core_test.sv
